### design/m4alu_pkg.sv
// Shared types, constants and helpers for the 4x4 matrix unit.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package m4alu_pkg;

  // Matrix geometry and element format
  localparam int DIM           = 4;
  localparam int ROW_W         = $clog2(DIM);
  localparam int ELEM_W        = 32;
  localparam int ROW_BITS      = DIM * ELEM_W;
  localparam int PROD_W        = 2 * ELEM_W;
  localparam int PAIR_W        = PROD_W + 1;
  localparam int ACC_W         = PROD_W + 2;
  localparam int FUNC_W        = 2;
  localparam int FRAC_BITS_DEF = 16;

  // Operation codes
  localparam logic [FUNC_W-1:0] OP_ADD = 2'd0;
  localparam logic [FUNC_W-1:0] OP_SUB = 2'd1;
  localparam logic [FUNC_W-1:0] OP_MUL = 2'd2;
  localparam logic [FUNC_W-1:0] OP_TRN = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             load;     // write one input row into the A and B stores
    logic [ROW_W-1:0] row;      // row being loaded or computed
    logic             prod_en;  // capture products and selected operands
    logic             psum_en;  // capture pairwise product sums
    logic             out_en;   // capture the finished result row
  } m4_cmd_t;

  // Clamp a wide signed value to the signed element range
  function automatic logic [ELEM_W-1:0] sat_elem(input logic [ACC_W-1:0] v);
    logic [ACC_W-ELEM_W:0] top;
    logic [ELEM_W-1:0]     res;
    top = v[ACC_W-1:ELEM_W-1];
    if ((&top) || !(|top)) begin
      res = v[ELEM_W-1:0];
    end else if (v[ACC_W-1]) begin
      res = {1'b1, {(ELEM_W-1){1'b0}}};
    end else begin
      res = {1'b0, {(ELEM_W-1){1'b1}}};
    end
    return res;
  endfunction

endpackage

### design/m4alu_ctrl.sv
// Sequencer for the 4x4 matrix unit: row loading, per-row compute steps, output handshake.
// Depends on m4alu_pkg for the command struct and geometry constants.
`timescale 1ns / 1ps

module m4alu_ctrl
  import m4alu_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output m4_cmd_t cmd
);

  localparam logic [2:0] S_LOAD = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_OUT  = 3'd4;

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(DIM - 1);

  logic [2:0]       state_r, state_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic             in_fire;

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = (state_r == S_OUT);
  assign in_fire    = in_tvalid && in_tready;

  // Next state, row counter and datapath commands
  always_comb begin
    state_nxt   = state_r;
    row_nxt     = row_r;
    cmd.load    = 1'b0;
    cmd.row     = row_r;
    cmd.prod_en = 1'b0;
    cmd.psum_en = 1'b0;
    cmd.out_en  = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          if (row_r == ROW_LAST) begin
            row_nxt   = '0;
            state_nxt = S_MUL;
          end else begin
            row_nxt = row_r + ROW_W'(1);
          end
        end
      end
      S_MUL: begin
        cmd.prod_en = 1'b1;
        state_nxt   = S_SUM;
      end
      S_SUM: begin
        cmd.psum_en = 1'b1;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        cmd.out_en = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          if (row_r == ROW_LAST) begin
            row_nxt   = '0;
            state_nxt = S_LOAD;
          end else begin
            row_nxt   = row_r + ROW_W'(1);
            state_nxt = S_MUL;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
        row_nxt   = '0;
      end
    endcase
  end

  // Hold state and row counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      row_r   <= '0;
    end else begin
      state_r <= state_nxt;
      row_r   <= row_nxt;
    end
  end

endmodule

### design/m4alu_dp.sv
// Datapath of the 4x4 matrix unit: A/B row stores, product stage, sum stage, result register.
// Depends on m4alu_pkg; driven by commands from m4alu_ctrl.
`timescale 1ns / 1ps

module m4alu_dp
  import m4alu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  m4_cmd_t               cmd,
  input  logic [2*ROW_BITS-1:0] in_data,
  input  logic [FUNC_W-1:0]     in_func,
  output logic [ROW_BITS-1:0]   out_data,
  output logic [ROW_W-1:0]      out_row,
  output logic                  out_last
);

  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(DIM - 1);

  logic signed [ELEM_W-1:0] a_r     [DIM][DIM];
  logic signed [ELEM_W-1:0] b_r     [DIM][DIM];
  logic signed [ELEM_W-1:0] arow_r  [DIM];
  logic signed [ELEM_W-1:0] acol_r  [DIM];
  logic signed [ELEM_W-1:0] brow_r  [DIM];
  logic signed [PROD_W-1:0] prod_r  [DIM][DIM];
  logic signed [PAIR_W-1:0] pair_r  [2][DIM];
  logic [ELEM_W-1:0]        res_r   [DIM];
  logic [FUNC_W-1:0]        op_r;
  logic [ROW_W-1:0]         row_r;
  logic                     last_r;

  logic signed [PROD_W-1:0] term    [DIM][DIM];
  logic [ELEM_W-1:0]        res_nxt [DIM];

  // Store one incoming row; the function of the final row wins
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int c = 0; c < DIM; c++) begin
        a_r[cmd.row][c] <= in_data[c*ELEM_W +: ELEM_W];
        b_r[cmd.row][c] <= in_data[ROW_BITS + c*ELEM_W +: ELEM_W];
      end
      op_r <= in_func;
    end
  end

  // Form all products for this result row and pick its operands
  always_ff @(posedge clk) begin
    if (cmd.prod_en) begin
      for (int k = 0; k < DIM; k++) begin
        arow_r[k] <= a_r[cmd.row][k];
        acol_r[k] <= a_r[k][cmd.row];
        brow_r[k] <= b_r[cmd.row][k];
        for (int c = 0; c < DIM; c++) begin
          prod_r[k][c] <= a_r[cmd.row][k] * b_r[k][c];
        end
      end
      row_r  <= cmd.row;
      last_r <= (cmd.row == ROW_LAST);
    end
  end

  // Drop the fraction bits, rounding toward minus infinity
  always_comb begin
    for (int k = 0; k < DIM; k++) begin
      for (int c = 0; c < DIM; c++) begin
        term[k][c] = prod_r[k][c] >>> FRAC_BITS;
      end
    end
  end

  // Add the shifted terms in pairs
  always_ff @(posedge clk) begin
    if (cmd.psum_en) begin
      for (int c = 0; c < DIM; c++) begin
        pair_r[0][c] <= PAIR_W'(term[0][c]) + PAIR_W'(term[1][c]);
        pair_r[1][c] <= PAIR_W'(term[2][c]) + PAIR_W'(term[3][c]);
      end
    end
  end

  // Finish the selected operation; add, subtract and multiply results saturate
  always_comb begin
    logic signed [ACC_W-1:0]  acc;
    logic signed [ELEM_W:0]   sum;
    for (int c = 0; c < DIM; c++) begin
      acc = '0;
      sum = '0;
      res_nxt[c] = '0;
      unique case (op_r)
        OP_ADD: begin
          sum        = (ELEM_W+1)'(arow_r[c]) + (ELEM_W+1)'(brow_r[c]);
          res_nxt[c] = sat_elem(ACC_W'(sum));
        end
        OP_SUB: begin
          sum        = (ELEM_W+1)'(arow_r[c]) - (ELEM_W+1)'(brow_r[c]);
          res_nxt[c] = sat_elem(ACC_W'(sum));
        end
        OP_MUL: begin
          acc        = ACC_W'(pair_r[0][c]) + ACC_W'(pair_r[1][c]);
          res_nxt[c] = sat_elem(acc);
        end
        OP_TRN: begin
          res_nxt[c] = acol_r[c];
        end
        default: begin
          res_nxt[c] = '0;
        end
      endcase
    end
  end

  // Hold the finished row for the output handshake
  always_ff @(posedge clk) begin
    if (cmd.out_en) begin
      for (int c = 0; c < DIM; c++) begin
        res_r[c] <= res_nxt[c];
      end
      out_row  <= row_r;
      out_last <= last_r;
    end
  end

  always_comb begin
    for (int c = 0; c < DIM; c++) begin
      out_data[c*ELEM_W +: ELEM_W] = res_r[c];
    end
  end

endmodule

### design/matrix4_alu.sv
// 4x4 signed Q16.16 matrix unit (add, subtract, multiply, transpose): top level.
// Depends on m4alu_pkg, m4alu_ctrl and m4alu_dp.
//
// Send four words, one row of A and one row of B each, rows 0 to 3 in order; the
// operation is taken from the fourth word. The unit then returns four result words,
// rows 0 to 3, with the row number on out_tuser and out_tlast on row 3. Each result row
// passes through the product register, the pairwise-sum register and the saturating
// result register, where it waits until taken; the input is closed from the fourth
// load until the last row is taken.
// Products are shifted right arithmetically by FRAC_BITS; add, subtract and multiply
// results saturate to the signed 32-bit range.
`timescale 1ns / 1ps

module matrix4_alu
  import m4alu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [2*ROW_BITS-1:0] in_tdata,   // a0, a1, a2, a3, b0, b1, b2, b3
  input  logic [FUNC_W-1:0]     in_tuser,   // func
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [ROW_BITS-1:0]   out_tdata,  // c0, c1, c2, c3
  output logic [ROW_W-1:0]      out_tuser,  // row_index
  output logic                  out_tlast   // last_row
);

  m4_cmd_t cmd;

  m4alu_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  m4alu_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .in_data  (in_tdata),
    .in_func  (in_tuser),
    .out_data (out_tdata),
    .out_row  (out_tuser),
    .out_last (out_tlast)
  );

endmodule
